// File: src/sdff_pkg.sv
`default_nettype none

package sdff_pkg;

  // Fixed field widths
  localparam int VAL_W    = 64;
  localparam int CHAR_W   = 8;
  localparam int DIGITS   = 20;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int NDW      = 5;
  localparam int BITCNT_W = 6;
  localparam int CALC_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int MAX_FIELD_DEF = 64;

  // Characters
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_JUSTIFY    = 3'd0,
    REG_FORCE_PLUS      = 3'd1,
    REG_SPACE_SIGN      = 3'd2,
    REG_ZERO_PAD        = 3'd3,
    REG_PRECISION_GIVEN = 3'd4,
    REG_MIN_DIGITS      = 3'd5,
    REG_FIELD_WIDTH     = 3'd6
  } sdff_reg_e;

  // Converter states
  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_NORM,
    C_DONE
  } sdff_conv_e;

  // Character source in the emitter
  typedef enum logic [2:0] {
    SRC_LPAD,
    SRC_SIGN,
    SRC_ZPAD,
    SRC_LEAD,
    SRC_DIGIT,
    SRC_RPAD
  } sdff_src_e;

  typedef struct packed {
    logic             left_justify;
    logic             force_plus;
    logic             space_sign;
    logic             zero_pad;
    logic             precision_given;
    logic [5:0]       min_digits;
    logic [6:0]       field_width;
  } sdff_cfg_t;

  // Converted number: normalized BCD (most significant digit on top)
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [NDW-1:0]   nd;
    logic             neg;
  } sdff_num_t;

endpackage

`default_nettype wire

// File: src/sdff_bcd_conv.sv
`default_nettype none

module sdff_bcd_conv
  import sdff_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         num_valid_o,
  output sdff_num_t                    num_o,
  input  wire logic                    num_ack_i
);

  sdff_conv_e state_q, state_d;

  logic [VAL_W-1:0]    mag_q;
  logic [BCD_W-1:0]    bcd_q;
  logic [BITCNT_W-1:0] cnt_q;
  logic [NDW-1:0]      nd_q;
  logic                neg_q;

  logic [BCD_W-1:0] adj;
  logic             top_zero;

  // Add three to every digit above four before the shift
  always_comb begin
    logic [3:0] dg;
    adj = '0;
    for (int k = 0; k < DIGITS; k++) begin
      dg = bcd_q[4*k +: 4];
      adj[4*k +: 4] = (dg > 4'd4) ? dg + 4'd3 : dg;
    end
  end

  assign top_zero = (bcd_q[BCD_W-1 -: 4] == 4'd0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (in_valid_i) state_d = C_SHIFT;
      C_SHIFT: if (cnt_q == '0) state_d = C_NORM;
      C_NORM:  if (!(top_zero && nd_q > NDW'(1))) state_d = C_DONE;
      C_DONE:  if (num_ack_i) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = (state_q == C_IDLE);
    num_valid_o = (state_q == C_DONE);
    num_o.bcd   = bcd_q;
    num_o.nd    = nd_q;
    num_o.neg   = neg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shift the magnitude into the BCD register, then drop leading zero digits
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          mag_q <= value_i[VAL_W-1] ? (~value_i) + VAL_W'(1) : value_i;
          neg_q <= value_i[VAL_W-1];
          bcd_q <= '0;
          cnt_q <= BITCNT_W'(VAL_W - 1);
        end
      end
      C_SHIFT: begin
        bcd_q <= {adj[BCD_W-2:0], mag_q[VAL_W-1]};
        mag_q <= {mag_q[VAL_W-2:0], 1'b0};
        cnt_q <= cnt_q - BITCNT_W'(1);
        nd_q  <= NDW'(DIGITS);
      end
      C_NORM: begin
        if (top_zero && nd_q > NDW'(1)) begin
          bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
          nd_q  <= nd_q - NDW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/sdff_emit.sv
`default_nettype none

module sdff_emit
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire sdff_num_t     num_i,
  input  wire sdff_cfg_t     cfg_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [CHAR_W-1:0]  char_o,
  output logic               last_o
);

  localparam int LW = $clog2(MAX_FIELD + 1);

  logic              busy_q;
  logic [LW-1:0]     lpad_q, zpad_q, lead_q, total_q;
  logic [NDW-1:0]    ndig_q;
  logic              sign_pend_q;
  logic [CHAR_W-1:0] sign_q;
  logic [BCD_W-1:0]  bcd_q;
  logic              out_valid_q, last_q;
  logic [CHAR_W-1:0] char_q;

  // Field layout worked out at load
  logic [CALC_W-1:0] nd8, md8, lim, mind, fw8, wmax, width, dmax, body, pad, tot, lead;
  logic              has_sign, zfill;
  logic [CHAR_W-1:0] sign_ch;

  always_comb begin
    nd8      = CALC_W'(num_i.nd);
    md8      = CALC_W'(cfg_i.min_digits);
    lim      = CALC_W'(MAX_FIELD - 1);
    mind     = cfg_i.precision_given ? ((md8 > lim) ? lim : md8) : '0;
    fw8      = CALC_W'(cfg_i.field_width);
    wmax     = CALC_W'(MAX_FIELD);
    width    = (fw8 > wmax) ? wmax : fw8;
    has_sign = num_i.neg | cfg_i.force_plus | cfg_i.space_sign;
    sign_ch  = num_i.neg ? CH_MINUS : (cfg_i.force_plus ? CH_PLUS : CH_SPACE);
    dmax     = (mind > nd8) ? mind : nd8;
    body     = dmax + CALC_W'(has_sign);
    pad      = (width > body) ? width - body : '0;
    tot      = (width > body) ? width : body;
    lead     = (mind > nd8) ? mind - nd8 : '0;
    zfill    = cfg_i.zero_pad & ~cfg_i.precision_given & ~cfg_i.left_justify;
  end

  // Pick the source of the next character
  sdff_src_e         src;
  logic [CHAR_W-1:0] next_ch;
  logic              advance;

  always_comb begin
    if (lpad_q != '0) begin
      src = SRC_LPAD;
      next_ch = CH_SPACE;
    end else if (sign_pend_q) begin
      src = SRC_SIGN;
      next_ch = sign_q;
    end else if (zpad_q != '0) begin
      src = SRC_ZPAD;
      next_ch = CH_ZERO;
    end else if (lead_q != '0) begin
      src = SRC_LEAD;
      next_ch = CH_ZERO;
    end else if (ndig_q != '0) begin
      src = SRC_DIGIT;
      next_ch = CH_ZERO | CHAR_W'(bcd_q[BCD_W-1 -: 4]);
    end else begin
      src = SRC_RPAD;
      next_ch = CH_SPACE;
    end
  end

  assign advance = busy_q && (!out_valid_q || out_ready_i);

  // Control: busy flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
      end else if (advance && total_q == LW'(1)) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: load the layout, then count down one character per request
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lpad_q      <= (!cfg_i.left_justify && !zfill) ? LW'(pad) : '0;
      zpad_q      <= zfill ? LW'(pad) : '0;
      lead_q      <= LW'(lead);
      total_q     <= LW'(tot);
      ndig_q      <= num_i.nd;
      sign_pend_q <= has_sign;
      sign_q      <= sign_ch;
      bcd_q       <= num_i.bcd;
    end else if (advance) begin
      char_q  <= next_ch;
      last_q  <= (total_q == LW'(1));
      total_q <= total_q - LW'(1);
      case (src)
        SRC_LPAD:  lpad_q <= lpad_q - LW'(1);
        SRC_SIGN:  sign_pend_q <= 1'b0;
        SRC_ZPAD:  zpad_q <= zpad_q - LW'(1);
        SRC_LEAD:  lead_q <= lead_q - LW'(1);
        SRC_DIGIT: begin
          ndig_q <= ndig_q - NDW'(1);
          bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign char_o      = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: src/signed_decimal_field_formatter.sv
// Signed decimal field formatter (printf %d style).
// Input channel: one 64-bit two's complement value per request
// (in_valid_i / in_ready_o / value_i). Output channel: one ASCII character
// per request (out_valid_o / out_ready_i / char_out_o), with last_char_o
// marking the final character of the field.
// Configuration: write cfg_wdata_i to register cfg_idx_i when cfg_we_i is
// high (0 left justify, 1 force plus, 2 space sign, 3 zero pad,
// 4 precision given, 5 min digits, 6 field width); other indexes are
// dropped. Write only while no value is in flight.
// Processing: a value is shifted from binary into BCD, then its leading
// zero digits are dropped, then it is handed off to the emitter, which
// registers the first character of the field.
// The converter and the character emitter overlap, so a new value is
// taken while the previous field is still being sent; a field holds up
// to MAX_FIELD characters, 64 by default.
// When the receiver stalls, the current character holds and the emitter
// waits; the converter finishes and then holds its result.
// Reset zeroes the config and control registers; a value in flight is dropped.
`default_nettype none

module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [VAL_W-1:0]      value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [CHAR_W-1:0]                 char_out_o,
  output logic                              last_char_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_wdata_i
);

  sdff_cfg_t cfg_q;
  sdff_num_t num;
  logic      num_valid, load, emit_busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT_JUSTIFY:    cfg_q.left_justify    <= cfg_wdata_i[0];
        REG_FORCE_PLUS:      cfg_q.force_plus      <= cfg_wdata_i[0];
        REG_SPACE_SIGN:      cfg_q.space_sign      <= cfg_wdata_i[0];
        REG_ZERO_PAD:        cfg_q.zero_pad        <= cfg_wdata_i[0];
        REG_PRECISION_GIVEN: cfg_q.precision_given <= cfg_wdata_i[0];
        REG_MIN_DIGITS:      cfg_q.min_digits      <= cfg_wdata_i[5:0];
        REG_FIELD_WIDTH:     cfg_q.field_width     <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  sdff_bcd_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .num_valid_o (num_valid),
    .num_o       (num),
    .num_ack_i   (load)
  );

  // Hand the converted number over once the emitter is free
  assign load = num_valid && !emit_busy;

  sdff_emit #(
    .MAX_FIELD (MAX_FIELD)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .num_i       (num),
    .cfg_i       (cfg_q),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_o      (char_out_o),
    .last_o      (last_char_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("converter took a request while busy");

  a_emit_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> emit_busy)
    else $error("emitter not busy after hand-off");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_out_o == CH_SPACE || char_out_o == CH_PLUS ||
                     char_out_o == CH_MINUS ||
                     (char_out_o >= CH_ZERO && char_out_o <= 8'h39)))
    else $error("illegal character in field");
`endif

endmodule

`default_nettype wire
